FILE: rtl/assert_macros.svh
// Assertion helpers; every check is sampled on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every enabled clock edge.
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// If the trigger holds, the consequence must hold on the same edge.
`define CHK_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssmm_pkg.sv
package ssmm_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int VAL_BITS    = 32;
  localparam int TIME_BITS   = 32;
  localparam int SUM_BITS    = 48;
  localparam int TOTAL_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_CAP = {COUNT_BITS{1'b1}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // One closed series, handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]      count;
    logic signed [VAL_BITS-1:0] min_v;
    logic signed [VAL_BITS-1:0] max_v;
    logic [TIME_BITS-1:0]       span_start;
    logic [TIME_BITS-1:0]       span_end;
    logic                       saturated;
  } series_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [TOTAL_BITS-1:0] clamp_total(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+TOTAL_BITS-1:0] cx;
    cx = (COUNT_BITS+TOTAL_BITS)'(c);
    if (cx > (COUNT_BITS+TOTAL_BITS)'({TOTAL_BITS{1'b1}})) begin
      return {TOTAL_BITS{1'b1}};
    end
    return cx[TOTAL_BITS-1:0];
  endfunction

endpackage

FILE: rtl/ssmm_if.sv
interface ssmm_sample_if import ssmm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [VAL_BITS-1:0]  sample_value;
  logic [TIME_BITS-1:0]        sample_time;
  logic                        has_sample;
  logic                        last_of_series;
  logic [TIME_BITS-1:0]        window_start;
  logic [TIME_BITS-1:0]        window_end;

  modport source (output valid, sample_value, sample_time, has_sample, last_of_series,
                  window_start, window_end, input ready);
  modport sink (input valid, sample_value, sample_time, has_sample, last_of_series,
                window_start, window_end, output ready);
endinterface

interface ssmm_result_if import ssmm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [VAL_BITS-1:0]  mean_value;
  logic signed [VAL_BITS-1:0]  min_value;
  logic signed [VAL_BITS-1:0]  max_value;
  logic [TIME_BITS-1:0]        span_start;
  logic [TIME_BITS-1:0]        span_end;
  logic [TOTAL_BITS-1:0]       sample_total;
  logic                        overflow;

  modport source (output valid, mean_value, min_value, max_value, span_start, span_end,
                  sample_total, overflow, input ready);
  modport sink (input valid, mean_value, min_value, max_value, span_start, span_end,
                sample_total, overflow, output ready);
endinterface

FILE: rtl/ssmm_front.sv
module ssmm_front import ssmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ssmm_sample_if.sink       samples,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  queue_status_t     q_status,
  output logic              push,
  output series_rec_t       push_rec
);

  logic                       span_from_inputs;
  logic signed [SUM_BITS-1:0] running_sum;
  logic [COUNT_BITS-1:0]      running_count;
  logic signed [VAL_BITS-1:0] running_min;
  logic signed [VAL_BITS-1:0] running_max;
  logic [TIME_BITS-1:0]       first_time;
  logic [TIME_BITS-1:0]       latest_time;
  logic                       saturated;

  logic signed [SUM_BITS-1:0] sum_next;
  logic [COUNT_BITS-1:0]      count_next;
  logic signed [VAL_BITS-1:0] min_next;
  logic signed [VAL_BITS-1:0] max_next;
  logic [TIME_BITS-1:0]       first_next;
  logic [TIME_BITS-1:0]       latest_next;
  logic                       sat_next;
  logic signed [SUM_BITS:0]   sum_wide;
  logic                       accept;

  assign samples.ready = !q_status.full;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    sum_next    = running_sum;
    count_next  = running_count;
    min_next    = running_min;
    max_next    = running_max;
    first_next  = first_time;
    latest_next = latest_time;
    sat_next    = saturated;
    sum_wide    = (SUM_BITS+1)'(running_sum) + (SUM_BITS+1)'(samples.sample_value);
    if (samples.has_sample) begin
      if (running_count == '0) begin
        min_next   = samples.sample_value;
        max_next   = samples.sample_value;
        first_next = samples.sample_time;
      end else begin
        if (samples.sample_value < running_min) min_next = samples.sample_value;
        if (samples.sample_value > running_max) max_next = samples.sample_value;
      end
      latest_next = samples.sample_time;
      // once the count is pinned, later samples only touch min/max/time and set saturated
      if (running_count == COUNT_CAP) begin
        sat_next = 1'b1;
      end else begin
        count_next = running_count + 1'b1;
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
          sat_next = 1'b1;
          sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_next = sum_wide[SUM_BITS-1:0];
        end
      end
    end
  end

  assign push                = accept && samples.last_of_series;
  assign push_rec.sum        = sum_next;
  assign push_rec.count      = count_next;
  assign push_rec.min_v      = min_next;
  assign push_rec.max_v      = max_next;
  assign push_rec.span_start = span_from_inputs ? samples.window_start : first_next;
  assign push_rec.span_end   = span_from_inputs ? samples.window_end : latest_next;
  assign push_rec.saturated  = sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_from_inputs <= 1'b0;
    end else if (cfg_we) begin
      span_from_inputs <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      running_sum   <= '0;
      running_count <= '0;
      running_min   <= '0;
      running_max   <= '0;
      first_time    <= '0;
      latest_time   <= '0;
      saturated     <= 1'b0;
    end else if (accept) begin
      running_sum   <= sum_next;
      running_count <= count_next;
      running_min   <= min_next;
      running_max   <= max_next;
      first_time    <= first_next;
      latest_time   <= latest_next;
      saturated     <= sat_next;
    end
  end

endmodule

FILE: rtl/ssmm_queue.sv
module ssmm_queue import ssmm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  series_rec_t   push_rec,
  input  logic          pop,
  output series_rec_t   pop_rec,
  output queue_status_t status
);

  series_rec_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     fill;

  assign status.full  = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_rec      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/ssmm_back.sv
module ssmm_back import ssmm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  queue_status_t  q_status,
  input  series_rec_t    pop_rec,
  output logic           pop,
  ssmm_result_if.source  results
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                     state;
  logic [SUM_BITS-1:0]        quo;
  logic [COUNT_BITS-1:0]      rem;
  logic [COUNT_BITS-1:0]      divisor;
  logic [STEP_BITS-1:0]       step;
  logic                       neg;

  logic signed [VAL_BITS-1:0] mean_r;
  logic signed [VAL_BITS-1:0] min_r;
  logic signed [VAL_BITS-1:0] max_r;
  logic [TIME_BITS-1:0]       start_r;
  logic [TIME_BITS-1:0]       end_r;
  logic [TOTAL_BITS-1:0]      total_r;
  logic                       ovf_r;

  logic [COUNT_BITS:0]        rem_sh;
  logic                       fits;
  logic [COUNT_BITS-1:0]      rem_next;
  logic [SUM_BITS-1:0]        quo_next;
  logic [SUM_BITS-1:0]        sum_mag;
  logic signed [VAL_BITS-1:0] mean_next;

  assign pop     = (state == S_IDLE) && !q_status.empty;
  assign sum_mag = pop_rec.sum[SUM_BITS-1] ? SUM_BITS'(-pop_rec.sum) : SUM_BITS'(pop_rec.sum);

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, quo[SUM_BITS-1]};
    fits     = rem_sh >= {1'b0, divisor};
    rem_next = fits ? COUNT_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[COUNT_BITS-1:0];
    quo_next = {quo[SUM_BITS-2:0], fits};
  end

  // clamp the quotient magnitude into Q16.16 and restore the sign
  always_comb begin
    if (!neg) begin
      if (quo_next > SUM_BITS'({1'b0, {(VAL_BITS-1){1'b1}}})) begin
        mean_next = {1'b0, {(VAL_BITS-1){1'b1}}};
      end else begin
        mean_next = quo_next[VAL_BITS-1:0];
      end
    end else begin
      if (quo_next > SUM_BITS'({1'b1, {(VAL_BITS-1){1'b0}}})) begin
        mean_next = {1'b1, {(VAL_BITS-1){1'b0}}};
      end else begin
        mean_next = -quo_next[VAL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            state <= (pop_rec.count == '0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (step == STEP_BITS'(SUM_BITS-1)) state <= S_OUT;
        end
        S_OUT: begin
          if (results.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      quo     <= sum_mag;
      rem     <= '0;
      divisor <= pop_rec.count;
      step    <= '0;
      neg     <= pop_rec.sum[SUM_BITS-1];
      mean_r  <= '0;
      min_r   <= pop_rec.min_v;
      max_r   <= pop_rec.max_v;
      start_r <= pop_rec.span_start;
      end_r   <= pop_rec.span_end;
      total_r <= clamp_total(pop_rec.count);
      ovf_r   <= pop_rec.saturated;
    end else if (state == S_DIV) begin
      quo  <= quo_next;
      rem  <= rem_next;
      step <= step + 1'b1;
      if (step == STEP_BITS'(SUM_BITS-1)) mean_r <= mean_next;
    end
  end

  assign results.valid        = (state == S_OUT);
  assign results.mean_value   = mean_r;
  assign results.min_value    = min_r;
  assign results.max_value    = max_r;
  assign results.span_start   = start_r;
  assign results.span_end     = end_r;
  assign results.sample_total = total_r;
  assign results.overflow     = ovf_r;

endmodule

FILE: rtl/series_min_max_mean_stats.sv
// Running min / max / mean over a series of timestamped Q16.16 samples. The
// front accumulator takes one request per cycle while the queue is not full;
// a request marked last_of_series closes the series and its totals go into a
// four-entry queue. The back divider computes sum / count one quotient bit
// per cycle over 48 divide steps; an empty series skips the divide. It takes
// a new series only after its last result is accepted, so closing requests
// coming faster fill the queue and the input stalls until an entry frees.
// span_from_inputs is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module series_min_max_mean_stats import ssmm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ssmm_sample_if.sink   samples,
  ssmm_result_if.source results,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic          q_push;
  logic          q_pop;
  series_rec_t   q_push_rec;
  series_rec_t   q_pop_rec;
  queue_status_t q_status;

  ssmm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .push      (q_push),
    .push_rec  (q_push_rec)
  );

  ssmm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .pop_rec  (q_pop_rec),
    .status   (q_status)
  );

  ssmm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_rec  (q_pop_rec),
    .pop      (q_pop),
    .results  (results)
  );

  `CHK_IMPLIES(a_no_push_full, q_push, !q_status.full, "close pushed into full queue")
  `CHK_IMPLIES(a_no_pop_empty, q_pop, !q_status.empty, "pop from empty queue")
  `CHK_IMPLIES(a_empty_zero, results.valid && results.sample_total == '0,
               results.mean_value == '0 && results.min_value == '0 && !results.overflow,
               "empty series result not zero")
  `CHK_IMPLIES(a_min_le_max, results.valid, results.min_value <= results.max_value,
               "min above max")

endmodule
